// ===== design/deque_with_sort_and_count_defines.svh =====
// Assertion macros for the deque block.
// Define SYNTH to drop every check.
`ifndef DEQUE_WITH_SORT_AND_COUNT_DEFINES_SVH
`define DEQUE_WITH_SORT_AND_COUNT_DEFINES_SVH

`ifndef SYNTH
// Holds at every edge outside reset.
`define DWSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
// Antecedent at one edge implies consequent at the next edge.
`define DWSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define DWSC_ASSERT(lbl, prop)
`define DWSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/dwsc_pkg.sv =====
package dwsc_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned MODE_W        = 3;
  localparam int unsigned STAT_W        = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SORT       = 3'd4,
    MODE_COUNT      = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_e;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // shared comparator flags
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== design/dwsc_ram.sv =====
module dwsc_ram #(
  parameter int unsigned DEPTH = dwsc_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [dwsc_pkg::VAL_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [dwsc_pkg::VAL_W-1:0] rdata_o
);

  logic [dwsc_pkg::VAL_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on collision
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/dwsc_cmp.sv =====
module dwsc_cmp (
  input  logic signed [dwsc_pkg::VAL_W-1:0] a_i,
  input  logic signed [dwsc_pkg::VAL_W-1:0] b_i,
  output dwsc_pkg::cmp_res_t                res_o
);

  assign res_o.gt = (a_i > b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

// ===== design/deque_with_sort_and_count.sv =====
// Flow: push, clear, refused ops and sort/count of fewer entries go from idle
// to S_EMIT. Pop reads in S_POP (registered RAM read). Count of n entries
// walks them in S_COUNT. Sort of n >= 2 entries runs bubble passes (at most n)
// through the single RAM read port and the one shared comparator.
// One word in flight: the next word is taken only once the FSM is back in S_IDLE.
// Reset (rst_ni low, async): FSM, front pointer, count and output valid clear.
module deque_with_sort_and_count #(
  parameter int unsigned DEPTH = dwsc_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dwsc_pkg::MODE_W-1:0]       mode_i,
  input  logic signed [dwsc_pkg::VAL_W-1:0] value_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [dwsc_pkg::VAL_W-1:0] result_value_o,
  output logic [dwsc_pkg::STAT_W-1:0]       status_o,
  output logic [CW-1:0]                     occupancy_o
);

  `include "deque_with_sort_and_count_defines.svh"

  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] POS_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0] POS_ONE  = AW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SORT_FIRST,
    S_SORT_RUN,
    S_SORT_END,
    S_COUNT,
    S_EMIT
  } state_e;

  // ring position of logical entry pos
  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                           input logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  state_e                      state_q, state_d;
  logic [AW-1:0]               front_q, front_d;
  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               idx_q, idx_d;       // logical position being walked
  logic [dwsc_pkg::VAL_W-1:0]  carry_q, carry_d;   // largest value so far in a pass
  logic                        swapped_q, swapped_d;
  logic [CW-1:0]               match_q, match_d;
  logic [dwsc_pkg::VAL_W-1:0]  value_q, value_d;
  logic [dwsc_pkg::VAL_W-1:0]  res_value_q, res_value_d;
  logic [dwsc_pkg::STAT_W-1:0] res_status_q, res_status_d;
  logic                        out_valid_q, out_valid_d;
  logic [dwsc_pkg::VAL_W-1:0]  out_value_q, out_value_d;
  logic [dwsc_pkg::STAT_W-1:0] out_status_q, out_status_d;
  logic [CW-1:0]               out_occ_q, out_occ_d;

  // RAM port and comparator hookup
  logic                        ram_we;
  logic [AW-1:0]               ram_wpos, ram_rpos;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [dwsc_pkg::VAL_W-1:0]  ram_wdata, ram_rdata;
  logic [dwsc_pkg::VAL_W-1:0]  cmp_a, cmp_b;
  dwsc_pkg::cmp_res_t          cmp_res;

  logic [CW-1:0]               cnt_m1;
  logic [CW-1:0]               match_sum;
  logic                        is_full, is_empty, is_last;

  assign cnt_m1    = count_q - CW'(1);
  assign is_full   = (count_q == CW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign is_last   = (idx_q == cnt_m1[AW-1:0]);
  assign match_sum = match_q + CW'(cmp_res.eq);

  assign ram_waddr = slot_f(front_q, ram_wpos);
  assign ram_raddr = slot_f(front_q, ram_rpos);

  dwsc_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dwsc_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign occupancy_o    = out_occ_q;

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    idx_d        = idx_q;
    carry_d      = carry_q;
    swapped_d    = swapped_q;
    match_d      = match_q;
    value_d      = value_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;

    ram_we    = 1'b0;
    ram_wpos  = '0;
    ram_rpos  = '0;
    ram_wdata = carry_q;
    cmp_a     = carry_q;
    cmp_b     = ram_rdata;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          value_d      = value_i;
          res_value_d  = '0;
          res_status_d = dwsc_pkg::STAT_DONE;
          state_d      = S_EMIT;
          case (dwsc_pkg::mode_e'(mode_i))
            dwsc_pkg::MODE_PUSH_FRONT: begin
              if (is_full) begin
                res_status_d = dwsc_pkg::STAT_FULL;
              end else begin
                // one slot behind the front, wrapping
                ram_we    = 1'b1;
                ram_wpos  = POS_LAST;
                ram_wdata = value_i;
                front_d   = slot_f(front_q, POS_LAST);
                count_d   = count_q + CW'(1);
              end
            end
            dwsc_pkg::MODE_PUSH_BACK: begin
              if (is_full) begin
                res_status_d = dwsc_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wpos  = count_q[AW-1:0];
                ram_wdata = value_i;
                count_d   = count_q + CW'(1);
              end
            end
            dwsc_pkg::MODE_POP_FRONT: begin
              if (is_empty) begin
                res_status_d = dwsc_pkg::STAT_EMPTY;
              end else begin
                ram_rpos = '0;
                front_d  = slot_f(front_q, POS_ONE);
                count_d  = cnt_m1;
                state_d  = S_POP;
              end
            end
            dwsc_pkg::MODE_POP_BACK: begin
              if (is_empty) begin
                res_status_d = dwsc_pkg::STAT_EMPTY;
              end else begin
                ram_rpos = cnt_m1[AW-1:0];
                count_d  = cnt_m1;
                state_d  = S_POP;
              end
            end
            dwsc_pkg::MODE_SORT: begin
              if (count_q > CW'(1)) begin
                ram_rpos = '0;
                state_d  = S_SORT_FIRST;
              end
            end
            dwsc_pkg::MODE_COUNT: begin
              if (!is_empty) begin
                ram_rpos = '0;
                idx_d    = '0;
                match_d  = '0;
                state_d  = S_COUNT;
              end
            end
            dwsc_pkg::MODE_CLEAR: begin
              front_d = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        res_value_d = ram_rdata;
        state_d     = S_EMIT;
      end

      // start of a bubble pass: entry 0 becomes the carried value
      S_SORT_FIRST: begin
        carry_d   = ram_rdata;
        ram_rpos  = POS_ONE;
        idx_d     = POS_ONE;
        swapped_d = 1'b0;
        state_d   = S_SORT_RUN;
      end

      // rdata holds entry idx; smaller of carry/rdata lands at idx-1
      S_SORT_RUN: begin
        ram_we   = 1'b1;
        ram_wpos = idx_q - AW'(1);
        if (cmp_res.gt) begin
          ram_wdata = ram_rdata;
          swapped_d = 1'b1;
        end else begin
          ram_wdata = carry_q;
          carry_d   = ram_rdata;
        end
        if (is_last) begin
          state_d = S_SORT_END;
        end else begin
          ram_rpos = idx_q + AW'(1);
          idx_d    = idx_q + AW'(1);
        end
      end

      // largest of the pass goes to the back
      S_SORT_END: begin
        ram_we    = 1'b1;
        ram_wpos  = idx_q;
        ram_wdata = carry_q;
        if (swapped_q) begin
          ram_rpos = '0;
          state_d  = S_SORT_FIRST;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_COUNT: begin
        cmp_a = ram_rdata;
        cmp_b = value_q;
        if (is_last) begin
          res_value_d = dwsc_pkg::VAL_W'(match_sum);
          state_d     = S_EMIT;
        end else begin
          match_d  = match_sum;
          ram_rpos = idx_q + AW'(1);
          idx_d    = idx_q + AW'(1);
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          out_occ_d    = count_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      front_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      carry_q      <= '0;
      swapped_q    <= 1'b0;
      match_q      <= '0;
      value_q      <= '0;
      res_value_q  <= '0;
      res_status_q <= dwsc_pkg::STAT_DONE;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= dwsc_pkg::STAT_DONE;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      carry_q      <= carry_d;
      swapped_q    <= swapped_d;
      match_q      <= match_d;
      value_q      <= value_d;
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_occ_q    <= out_occ_d;
    end
  end

  // checks
  `DWSC_ASSERT(a_count_in_range, count_q <= CW'(DEPTH))
  `DWSC_ASSERT_NEXT(a_one_word_in_flight, in_valid_i && in_ready_o, !in_ready_o)
  `DWSC_ASSERT_NEXT(a_full_push_no_change,
    in_valid_i && in_ready_o && is_full &&
    (mode_i == dwsc_pkg::MODE_PUSH_FRONT || mode_i == dwsc_pkg::MODE_PUSH_BACK),
    count_q == $past(count_q) && front_q == $past(front_q))
  `DWSC_ASSERT(a_sort_idx_in_span, state_q != S_SORT_RUN || (idx_q != '0 && idx_q <= cnt_m1[AW-1:0]))

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned OCC_W       = 7;
  localparam int unsigned RANDOM_WORDS = 680;
  localparam int unsigned CALM_WORDS  = 80;    // tail of the run with no idling
  localparam int unsigned QUIET_LIMIT = 20000; // longer than a full sort of all slots
  localparam int unsigned DRAIN_WAIT  = 100;

  // mode seven is not decoded by the block: it must act as a no-op
  localparam logic [dwsc_pkg::MODE_W-1:0] MODE_NOP = 3'd7;

  localparam logic [dwsc_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [dwsc_pkg::VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [dwsc_pkg::VAL_W-1:0] VAL_NEG1 = 32'hffff_ffff;

  typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_MIXED} lean_e;

  typedef struct {
    logic signed [dwsc_pkg::VAL_W-1:0] value;
    logic [dwsc_pkg::STAT_W-1:0]       status;
    logic [OCC_W-1:0]                  occupancy;
  } reply_t;

  // Shadow deque plus queue of replies still owed by the block.
  class deque_scoreboard;
    logic [dwsc_pkg::VAL_W-1:0] ring[SLOTS];
    logic [5:0]                 head;
    logic [OCC_W-1:0]           held;
    reply_t                     owed_replies[$];
    int unsigned                mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      head = '0;
      held = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch @%0t: %s", $time, msg);
    endtask

    // bubble passes over the occupied span until none swaps, signed ascending
    function void sort_span();
      logic [dwsc_pkg::VAL_W-1:0] tmp;
      logic [5:0]                 sa, sb;
      bit                         swapped;
      int unsigned                i;
      do begin
        swapped = 1'b0;
        for (i = 0; i + 1 < held; i++) begin
          sa = head + i[5:0];
          sb = head + i[5:0] + 6'd1;
          if ($signed(ring[sa]) > $signed(ring[sb])) begin
            tmp = ring[sa];
            ring[sa] = ring[sb];
            ring[sb] = tmp;
            swapped = 1'b1;
          end
        end
      end while (swapped);
    endfunction

    function void note_word(logic [dwsc_pkg::MODE_W-1:0] mode,
                            logic [dwsc_pkg::VAL_W-1:0] value);
      reply_t      r;
      int unsigned i;
      r.value = '0;
      r.status = dwsc_pkg::STAT_DONE;
      case (mode)
        dwsc_pkg::MODE_PUSH_FRONT, dwsc_pkg::MODE_PUSH_BACK: begin
          if (held >= SLOTS) begin
            r.status = dwsc_pkg::STAT_FULL;
          end else if (mode == dwsc_pkg::MODE_PUSH_FRONT) begin
            head = head - 6'd1;
            ring[head] = value;
            held++;
          end else begin
            ring[head + held[5:0]] = value;
            held++;
          end
        end
        dwsc_pkg::MODE_POP_FRONT: begin
          if (held == 0) begin
            r.status = dwsc_pkg::STAT_EMPTY;
          end else begin
            r.value = ring[head];
            head = head + 6'd1;
            held--;
          end
        end
        dwsc_pkg::MODE_POP_BACK: begin
          if (held == 0) begin
            r.status = dwsc_pkg::STAT_EMPTY;
          end else begin
            r.value = ring[head + held[5:0] - 6'd1];
            held--;
          end
        end
        dwsc_pkg::MODE_SORT: sort_span();
        dwsc_pkg::MODE_COUNT: begin
          for (i = 0; i < held; i++)
            if (ring[head + i[5:0]] == value) r.value++;
        end
        dwsc_pkg::MODE_CLEAR: begin
          held = '0;
          head = '0;
        end
        default: ;
      endcase
      r.occupancy = held;
      owed_replies.push_back(r);
    endfunction

    task check_word(logic signed [dwsc_pkg::VAL_W-1:0] value,
                    logic [dwsc_pkg::STAT_W-1:0] status,
                    logic [OCC_W-1:0] occupancy);
      reply_t r;
      if (owed_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result word value=%0d status=%0d occ=%0d",
                                  value, status, occupancy));
      end else begin
        r = owed_replies.pop_front();
        if (value !== r.value)
          report_mismatch($sformatf("result_value got %0d want %0d", value, r.value));
        if (status !== r.status)
          report_mismatch($sformatf("status got %0d want %0d", status, r.status));
        if (occupancy !== r.occupancy)
          report_mismatch($sformatf("occupancy got %0d want %0d", occupancy, r.occupancy));
      end
    endtask
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [dwsc_pkg::MODE_W-1:0]        mode = '0;
  logic signed [dwsc_pkg::VAL_W-1:0]  value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b1;
  logic signed [dwsc_pkg::VAL_W-1:0]  result_value;
  logic [dwsc_pkg::STAT_W-1:0]        status;
  logic [OCC_W-1:0]                   occupancy;

  bit              bursts_on = 1'b1;
  int unsigned     quiet_cycles = 0;
  deque_scoreboard board = new();

  deque_with_sort_and_count dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_value_o (result_value),
    .status_o       (status),
    .occupancy_o    (occupancy)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Offer one word, with an optional idle burst ahead of it; returns at the
  // edge where it is taken.
  task automatic send_word(input logic [dwsc_pkg::MODE_W-1:0] m,
                           input logic [dwsc_pkg::VAL_W-1:0] v);
    int unsigned gap;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode <= m;
    value <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    board.note_word(m, v);
  endtask

  // Mostly a small pool so counts find matches, plus extremes and full range.
  function automatic logic [dwsc_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return $urandom_range(0, 1) ? VAL_NEG1 : '0;
      3, 4, 5, 6: return 32'($urandom_range(0, 7)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [dwsc_pkg::MODE_W-1:0] pick_mode(lean_e lean);
    int unsigned r, push_pct;
    r = $urandom_range(0, 99);
    case (lean)
      LEAN_FILL:  push_pct = 85;
      LEAN_DRAIN: push_pct = 15;
      default:    push_pct = 50;
    endcase
    if (r < 8) return dwsc_pkg::MODE_COUNT;
    if (r < 11) return dwsc_pkg::MODE_SORT;
    if (r < 12) return dwsc_pkg::MODE_CLEAR;
    if (r < 13) return MODE_NOP;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? dwsc_pkg::MODE_PUSH_FRONT : dwsc_pkg::MODE_PUSH_BACK;
    return $urandom_range(0, 1) ? dwsc_pkg::MODE_POP_FRONT : dwsc_pkg::MODE_POP_BACK;
  endfunction

  // result side: sample before the edge updates, stall in bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && out_ready)
        board.check_word(result_value, status, occupancy);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ready <= 1'b1;
      end else if (rst_ni && bursts_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 10);
        out_ready <= 1'b0;
      end
    end
  end

  // hang detector: cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    lean_e lean;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty refusals, extremes, counts, sorts, clear, no-op mode
    send_word(dwsc_pkg::MODE_POP_FRONT, '0);
    send_word(dwsc_pkg::MODE_POP_BACK, '0);
    send_word(dwsc_pkg::MODE_COUNT, '0);
    send_word(dwsc_pkg::MODE_SORT, '0);
    send_word(MODE_NOP, VAL_NEG1);
    send_word(dwsc_pkg::MODE_PUSH_FRONT, VAL_MIN);
    send_word(dwsc_pkg::MODE_PUSH_BACK, VAL_MAX);
    send_word(dwsc_pkg::MODE_PUSH_FRONT, '0);
    send_word(dwsc_pkg::MODE_PUSH_BACK, VAL_NEG1);
    send_word(dwsc_pkg::MODE_PUSH_FRONT, VAL_NEG1);
    send_word(dwsc_pkg::MODE_COUNT, VAL_NEG1);
    send_word(dwsc_pkg::MODE_COUNT, VAL_MIN);
    send_word(dwsc_pkg::MODE_SORT, '0);
    send_word(dwsc_pkg::MODE_POP_FRONT, '0);
    send_word(dwsc_pkg::MODE_POP_BACK, '0);
    send_word(dwsc_pkg::MODE_COUNT, 32'd5);
    send_word(dwsc_pkg::MODE_SORT, '0);
    send_word(dwsc_pkg::MODE_PUSH_BACK, 32'h5555_5555);
    send_word(dwsc_pkg::MODE_PUSH_FRONT, 32'haaaa_aaaa);
    send_word(dwsc_pkg::MODE_CLEAR, '0);
    send_word(dwsc_pkg::MODE_POP_BACK, '0);
    send_word(dwsc_pkg::MODE_COUNT, '0);
    send_word(dwsc_pkg::MODE_PUSH_BACK, 32'd1);
    send_word(dwsc_pkg::MODE_SORT, '0);
    send_word(dwsc_pkg::MODE_POP_FRONT, '0);

    // random: epochs leaning to fill, drain or mix so full and empty both occur
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      case ((n / 100) % 3)
        0: lean = LEAN_FILL;
        1: lean = LEAN_DRAIN;
        default: lean = LEAN_MIXED;
      endcase
      if (n == RANDOM_WORDS - CALM_WORDS) bursts_on = 1'b0;
      send_word(pick_mode(lean), pick_value());
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
